FILE: design/afol_pkg.sv
package afol_pkg;

    localparam int MAX_ENTRIES = 6;
    localparam int TABLE_SLOTS = 6;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int ENTRY_W     = 48;
    localparam int REM_W       = 17;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef enum logic [2:0] {
        REG_TWO_SIDED   = 3'd0,
        REG_ENTRY_COUNT = 3'd1,
        REG_ENTRY_ZERO  = 3'd2,
        REG_ENTRY_ONE   = 3'd3,
        REG_ENTRY_TWO   = 3'd4,
        REG_ENTRY_THREE = 3'd5,
        REG_ENTRY_FOUR  = 3'd6,
        REG_ENTRY_FIVE  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] cosine;
        logic [7:0]         alpha_in;
    } item_t;

    typedef struct packed {
        logic [15:0] opacity;
        logic [7:0]  alpha_out;
    } result_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             unity;
        logic             interp;
        logic [IDX_W-1:0] seg;
        logic [REM_W-1:0] rem;
        logic [7:0]       alpha;
    } token_t;

    typedef struct packed {
        logic [15:0] o0;
        logic [15:0] o1;
        logic [15:0] recip;
    } seg_data_t;

    function automatic logic [15:0] field_step(input logic [ENTRY_W-1:0] e);
        return e[15:0];
    endfunction

    function automatic logic [15:0] field_recip(input logic [ENTRY_W-1:0] e);
        return e[31:16];
    endfunction

    function automatic logic [15:0] field_opac(input logic [ENTRY_W-1:0] e);
        return e[47:32];
    endfunction

endpackage

FILE: design/afol_cell.sv
module afol_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            cell_index,
    input  logic [2:0]            count,
    input  logic [15:0]           step,
    input  afol_pkg::token_t      tok_in,
    output afol_pkg::token_t      tok_out
);
    import afol_pkg::*;

    token_t tok_reg;
    token_t tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done)
        begin
            priority if (cell_index >= count)
            begin
                tok_next.done   = 1'b1;
                tok_next.interp = 1'b0;
                tok_next.seg    = count - 3'd1;
            end
            else if (tok_in.rem >= {1'b0, step})
            begin
                tok_next.rem = tok_in.rem - {1'b0, step};
            end
            else
            begin
                tok_next.done   = 1'b1;
                tok_next.interp = 1'b1;
                tok_next.seg    = cell_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: design/afol_interp.sv
module afol_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  afol_pkg::token_t      tok,
    input  afol_pkg::seg_data_t   seg,
    output logic                  done,
    output afol_pkg::result_t     result
);
    import afol_pkg::*;

    logic               s1_valid_reg;
    logic               s1_unity_reg;
    logic               s1_interp_reg;
    logic [15:0]        s1_o0_reg;
    logic [15:0]        s1_o1_reg;
    logic [31:0]        s1_prod_reg;
    logic [7:0]         s1_alpha_reg;

    logic               s2_valid_reg;
    logic               s2_unity_reg;
    logic               s2_interp_reg;
    logic [15:0]        s2_o0_reg;
    logic signed [49:0] s2_prod_reg;
    logic [7:0]         s2_alpha_reg;

    logic               s3_valid_reg;
    logic [15:0]        s3_opac_reg;
    logic [7:0]         s3_alpha_reg;

    logic               done_reg;
    result_t            result_reg;

    logic signed [16:0] diff;
    logic signed [49:0] shifted;
    logic signed [27:0] sum;
    logic [15:0]        s3_opac_next;
    logic [23:0]        scaled;
    logic [8:0]         faded;

    assign diff = $signed({1'b0, s1_o1_reg}) - $signed({1'b0, s1_o0_reg});
    assign shifted = s2_prod_reg >>> 23;
    assign sum = $signed({12'd0, s2_o0_reg}) + shifted[27:0];

    always_comb
    begin
        priority if (s2_unity_reg)
        begin
            s3_opac_next = ONE_Q15;
        end
        else if (s2_interp_reg)
        begin
            priority if (sum < 0)
                s3_opac_next = 16'd0;
            else if (sum > $signed({12'd0, ONE_Q15}))
                s3_opac_next = ONE_Q15;
            else
                s3_opac_next = sum[15:0];
        end
        else
        begin
            s3_opac_next = (s2_o0_reg > ONE_Q15) ? ONE_Q15 : s2_o0_reg;
        end
    end

    assign scaled = {8'd0, s3_opac_reg} * {16'd0, s3_alpha_reg};
    assign faded  = scaled[23:15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tok.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_unity_reg  <= tok.unity;
        s1_interp_reg <= tok.interp;
        s1_o0_reg     <= seg.o0;
        s1_o1_reg     <= seg.o1;
        s1_prod_reg   <= {16'd0, tok.rem[15:0]} * {16'd0, seg.recip};
        s1_alpha_reg  <= tok.alpha;

        s2_unity_reg  <= s1_unity_reg;
        s2_interp_reg <= s1_interp_reg;
        s2_o0_reg     <= s1_o0_reg;
        s2_prod_reg   <= $signed({17'd0, s1_prod_reg}) * 50'(diff);
        s2_alpha_reg  <= s1_alpha_reg;

        s3_opac_reg   <= s3_opac_next;
        s3_alpha_reg  <= s2_alpha_reg;

        result_reg.opacity   <= s3_opac_reg;
        result_reg.alpha_out <= faded[8] ? 8'd255 : faded[7:0];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/angle_fade_opacity_lerp_unit.sv
// channel   direction  handshake                     payload
// item      in         start && !busy                item_t (cosine, alpha_in)
// result    out        done strobe, one cycle        result_t (opacity, alpha_out)
// config    in         apb write: psel penable pwrite  8 registers, 64 bit, at 8*i
//
// a transaction is taken every cycle; busy stays low
// an item passes one entry stage, one cell per breakpoint after the first,
// then the two multiplies, the clamp and the alpha scale
// reset clears the config registers and the valid bits, emptying the pipeline
// the receiver cannot stall: a result is shown for one cycle only
module angle_fade_opacity_lerp_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  afol_pkg::item_t               item,
    output logic                          done,
    output afol_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afol_pkg::ADDR_W-1:0]   paddr,
    input  logic [afol_pkg::DATA_W-1:0]   pwdata,
    output logic [afol_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import afol_pkg::*;

    logic               two_sided_reg;
    logic [IDX_W-1:0]   count_reg;
    logic [ENTRY_W-1:0] entry_reg [TABLE_SLOTS];

    reg_index_t         reg_idx;
    logic [IDX_W-1:0]   entry_idx;
    logic               wr_en;

    logic [IDX_W-1:0]   n_eff;
    logic signed [16:0] cos_ext;
    logic signed [16:0] d_fold;
    logic signed [16:0] c0_ext;
    logic signed [17:0] diff;
    token_t             tok0_next;
    token_t             tok0_reg;
    token_t             chain [MAX_ENTRIES];
    token_t             tok_fin;
    logic [IDX_W-1:0]   lo_idx;
    logic [ENTRY_W-1:0] lo_entry;
    logic [ENTRY_W-1:0] hi_entry;
    seg_data_t          seg;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign reg_idx   = reg_index_t'(paddr[ADDR_W-1:3]);
    assign entry_idx = paddr[ADDR_W-1:3] - IDX_W'(REG_ENTRY_ZERO);
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_sided_reg <= 1'b0;
            count_reg     <= '0;
            for (int k = 0; k < TABLE_SLOTS; k++)
            begin
                entry_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TWO_SIDED:   two_sided_reg <= pwdata[0];
                REG_ENTRY_COUNT: count_reg <= pwdata[IDX_W-1:0];
                default:         entry_reg[entry_idx] <= pwdata[ENTRY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TWO_SIDED:   prdata = {63'd0, two_sided_reg};
            REG_ENTRY_COUNT: prdata = {{(DATA_W-IDX_W){1'b0}}, count_reg};
            default:         prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_reg[entry_idx]};
        endcase
    end

    assign n_eff = (count_reg > IDX_W'(MAX_ENTRIES)) ? IDX_W'(MAX_ENTRIES) : count_reg;

    // fold, then place against the first breakpoint
    assign cos_ext = {item.cosine[15], item.cosine};
    assign d_fold  = (two_sided_reg && item.cosine[15]) ? -cos_ext : cos_ext;
    assign c0_ext  = {entry_reg[0][15], entry_reg[0][15:0]};
    assign diff    = {d_fold[16], d_fold} - {c0_ext[16], c0_ext};

    always_comb
    begin
        tok0_next.valid  = start && !busy;
        tok0_next.unity  = (n_eff == '0);
        tok0_next.done   = (n_eff == '0) || (d_fold <= c0_ext);
        tok0_next.interp = 1'b0;
        tok0_next.seg    = '0;
        tok0_next.rem    = diff[REM_W-1:0];
        tok0_next.alpha  = item.alpha_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
        end
        else
        begin
            tok0_reg <= tok0_next;
        end
    end

    assign chain[0] = tok0_reg;

    for (genvar k = 1; k < MAX_ENTRIES; k++)
    begin : g_cell
        afol_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(k)),
            .count      (n_eff),
            .step       (field_step(entry_reg[k])),
            .tok_in     (chain[k-1]),
            .tok_out    (chain[k])
        );
    end

    // past the last cell: hold the last opacity
    always_comb
    begin
        tok_fin = chain[MAX_ENTRIES-1];
        if (!tok_fin.done)
        begin
            tok_fin.done   = 1'b1;
            tok_fin.interp = 1'b0;
            tok_fin.seg    = n_eff - IDX_W'(1);
        end
    end

    assign lo_idx = tok_fin.interp ? (tok_fin.seg - IDX_W'(1)) : tok_fin.seg;

    always_comb
    begin
        lo_entry = '0;
        hi_entry = '0;
        if (lo_idx < IDX_W'(TABLE_SLOTS))
        begin
            lo_entry = entry_reg[lo_idx];
        end
        if (tok_fin.seg < IDX_W'(TABLE_SLOTS))
        begin
            hi_entry = entry_reg[tok_fin.seg];
        end
        seg.o0    = field_opac(lo_entry);
        seg.o1    = field_opac(hi_entry);
        seg.recip = field_recip(lo_entry);
    end

    afol_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok    (tok_fin),
        .seg    (seg),
        .done   (done),
        .result (result)
    );

endmodule
